// ----- hdl/ssag_pkg.sv -----
// Shared widths, defaults and controller/datapath interface types for the spiral scan generator.
package ssag_pkg;

    localparam int MAX_DIM_DEF = 256;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam int GRID_DIM_W  = 9;
    localparam int START_W     = 8;
    localparam int COORD_W     = 8;

    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 2 * COORD_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;
        logic advance;
        logic count_cell;
        logic load_out;
        logic out_done;
    } t_dp_cmd;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic walk_active;
        logic walk_full;
        logic in_bounds;
        logic out_free;
    } t_dp_status;

endpackage

// ----- hdl/ssag_ctrl.sv -----
// Controller state machine that sequences one request through start, walk and result steps.
module ssag_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_restart,
    output logic                  o_s_tready,
    input  ssag_pkg::t_dp_status  i_status,
    output ssag_pkg::t_dp_cmd     o_cmd
);
    import ssag_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_moved, n_moved;
    logic   r_done,  n_done;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_moved = r_moved;
        n_done  = r_done;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_restart || !i_status.walk_active) begin
                        o_cmd.load_start = 1'b1;
                        n_done           = 1'b0;
                        n_state          = S_EMIT;
                    end else if (i_status.walk_full) begin
                        n_done  = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_moved = 1'b0;
                        n_done  = 1'b0;
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                // A position is only judged after at least one move.
                if (r_moved && i_status.in_bounds) begin
                    o_cmd.count_cell = 1'b1;
                    n_state          = S_EMIT;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_moved       = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.out_done = r_done;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_moved <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_moved <= n_moved;
            r_done  <= n_done;
        end
    end

endmodule

// ----- hdl/ssag_dp.sv -----
// Datapath holding the walk position, leg counters, cell count and the output register.
module ssag_dp #(
    parameter int MAX_DIM = ssag_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [ssag_pkg::GRID_DIM_W-1:0]   i_grid_rows,
    input  logic [ssag_pkg::GRID_DIM_W-1:0]   i_grid_cols,
    input  logic [ssag_pkg::START_W-1:0]      i_start_row,
    input  logic [ssag_pkg::START_W-1:0]      i_start_col,
    input  logic                              i_cfg_wr,
    input  ssag_pkg::t_dp_cmd                 i_cmd,
    output ssag_pkg::t_dp_status              o_status,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [ssag_pkg::COORD_W-1:0]      o_row,
    output logic [ssag_pkg::COORD_W-1:0]      o_col,
    output logic                              o_last,
    output logic                              o_done
);
    import ssag_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = $clog2(MAX_DIM) + 2;
    localparam int TW = $clog2(MAX_DIM * MAX_DIM + 1);
    localparam int CW = (DW > GRID_DIM_W) ? DW : GRID_DIM_W;
    localparam int SW = (DW > START_W) ? DW : START_W;

    typedef enum logic [1:0] {
        HEAD_EAST,
        HEAD_SOUTH,
        HEAD_WEST,
        HEAD_NORTH
    } t_heading;

    function automatic logic [DW-1:0] eff_dim(input logic [GRID_DIM_W-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        if (x == '0) begin
            eff_dim = DW'(1);
        end else if (x > CW'(MAX_DIM)) begin
            eff_dim = DW'(MAX_DIM);
        end else begin
            eff_dim = DW'(x);
        end
    endfunction

    function automatic logic [PW-1:0] eff_start(input logic [START_W-1:0] s,
                                                input logic [DW-1:0] dim);
        logic [SW-1:0] sx;
        logic [SW-1:0] dx;
        sx = SW'(s);
        dx = SW'(dim);
        if (sx >= dx) begin
            eff_start = PW'(dx - SW'(1));
        end else begin
            eff_start = PW'(sx);
        end
    endfunction

    logic [DW-1:0]          w_rows, w_cols;
    logic [2*DW-1:0]        w_prod;
    logic [TW-1:0]          r_total;

    logic signed [PW-1:0]   r_wrow, r_wcol, n_wrow, n_wcol;
    logic [PW-1:0]          r_leg, r_prog, n_leg, n_prog, w_prog_inc;
    t_heading               r_heading, n_heading;
    logic [TW-1:0]          r_cells;

    logic                   r_m_tvalid;
    logic [COORD_W-1:0]     r_row, r_col;
    logic                   r_last, r_done;

    assign w_rows = eff_dim(i_grid_rows);
    assign w_cols = eff_dim(i_grid_cols);
    assign w_prod = w_rows * w_cols;

    assign o_status.walk_active = (r_cells != '0);
    assign o_status.walk_full   = (r_cells >= r_total);
    assign o_status.in_bounds   = !r_wrow[PW-1] && !r_wcol[PW-1]
                                  && ($unsigned(r_wrow) < PW'(w_rows))
                                  && ($unsigned(r_wcol) < PW'(w_cols));
    assign o_status.out_free    = !r_m_tvalid || i_m_tready;

    // One step of the spiral: move, then turn at the end of a leg. The leg grows
    // each time the heading comes round to east or west.
    always_comb begin
        n_wrow     = r_wrow;
        n_wcol     = r_wcol;
        w_prog_inc = r_prog + PW'(1);
        n_prog     = w_prog_inc;
        n_leg      = r_leg;
        n_heading  = r_heading;
        unique case (r_heading)
            HEAD_EAST:  n_wcol = r_wcol + PW'(1);
            HEAD_SOUTH: n_wrow = r_wrow + PW'(1);
            HEAD_WEST:  n_wcol = r_wcol - PW'(1);
            HEAD_NORTH: n_wrow = r_wrow - PW'(1);
            default:    n_wrow = r_wrow;
        endcase
        if (w_prog_inc >= r_leg) begin
            n_prog    = '0;
            n_heading = t_heading'(2'(r_heading + 2'd1));
            if (r_heading == HEAD_SOUTH || r_heading == HEAD_NORTH) begin
                n_leg = r_leg + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrow     <= '0;
            r_wcol     <= '0;
            r_leg      <= PW'(1);
            r_prog     <= '0;
            r_heading  <= HEAD_EAST;
            r_cells    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cmd.load_start) begin
                r_wrow    <= eff_start(i_start_row, w_rows);
                r_wcol    <= eff_start(i_start_col, w_cols);
                r_leg     <= PW'(1);
                r_prog    <= '0;
                r_heading <= HEAD_EAST;
                r_cells   <= TW'(1);
            end else if (i_cmd.advance) begin
                r_wrow    <= n_wrow;
                r_wcol    <= n_wcol;
                r_leg     <= n_leg;
                r_prog    <= n_prog;
                r_heading <= n_heading;
            end
            if (i_cmd.count_cell) begin
                r_cells <= r_cells + TW'(1);
            end
            // Any register write abandons the walk.
            if (i_cfg_wr) begin
                r_cells <= '0;
            end
            if (i_cmd.load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_total <= w_prod[TW-1:0];
        if (i_cmd.load_out) begin
            r_row  <= i_cmd.out_done ? '0 : COORD_W'($unsigned(r_wrow));
            r_col  <= i_cmd.out_done ? '0 : COORD_W'($unsigned(r_wcol));
            r_last <= !i_cmd.out_done && (r_cells == r_total);
            r_done <= i_cmd.out_done;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_row      = r_row;
    assign o_col      = r_col;
    assign o_last     = r_last;
    assign o_done     = r_done;

endmodule

// ----- hdl/spiral_scan_address_generator.sv -----
// Top level of the spiral scan address generator: register file, controller and datapath.
//
//  Channel   Direction  Signals                          Carries
//  -------   ---------  -------------------------------  ------------------------------------
//  s stream  in         i_s_tvalid/o_s_tready/i_s_tdata  restart request
//  m stream  out        o_m_tvalid/i_m_tready/o_m_tdata  visited row/col, last flag, done flag
//  APB       in/out     psel/penable/pwrite/paddr/...    grid size and start cell registers
//
// A restart, or a request after the walk has finished, moves the controller to its emit state,
// which loads the result into the output register once the output is free. A request for the
// next cell first moves the walk until it reaches the next in-grid position: the walk steps
// one position per cycle, the step state then checks that the final position is in the grid,
// and the emit state loads the result. A new request is taken once the controller is back in idle.
// Reset is synchronous and leaves no walk active. A stalled output holds its result while
// the controller waits to load the next.
module spiral_scan_address_generator #(
    parameter int MAX_DIM = ssag_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ssag_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ssag_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ssag_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // Request stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [ssag_pkg::S_TDATA_W-1:0]     i_s_tdata,   // [0] restart, rest zero
    // Result stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [ssag_pkg::M_TDATA_W-1:0]     o_m_tdata,   // [7:0] row_out, [15:8] col_out
    output logic                               o_m_tlast,   // is_last
    output logic                               o_m_tuser    // done_res
);
    import ssag_pkg::*;

    localparam logic [1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [1:0] REG_GRID_COLS = 2'd1;
    localparam logic [1:0] REG_START_ROW = 2'd2;
    localparam logic [1:0] REG_START_COL = 2'd3;

    logic [GRID_DIM_W-1:0] r_grid_rows, r_grid_cols;
    logic [START_W-1:0]    r_start_row, r_start_col;
    logic                  w_cfg_wr;
    logic [1:0]            w_reg_idx;

    t_dp_cmd               w_cmd;
    t_dp_status            w_status;
    logic [COORD_W-1:0]    w_row, w_col;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    // Register writes land in the access cycle; the datapath sees the new values the
    // cycle after, and the write also drops any walk in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_DIM_W'(1);
            r_grid_cols <= GRID_DIM_W'(1);
            r_start_row <= '0;
            r_start_col <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_GRID_ROWS: r_grid_rows <= pwdata[GRID_DIM_W-1:0];
                REG_GRID_COLS: r_grid_cols <= pwdata[GRID_DIM_W-1:0];
                REG_START_ROW: r_start_row <= pwdata[START_W-1:0];
                REG_START_COL: r_start_col <= pwdata[START_W-1:0];
                default:       r_start_col <= r_start_col;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_GRID_ROWS: prdata = APB_DATA_W'(r_grid_rows);
            REG_GRID_COLS: prdata = APB_DATA_W'(r_grid_cols);
            REG_START_ROW: prdata = APB_DATA_W'(r_start_row);
            REG_START_COL: prdata = APB_DATA_W'(r_start_col);
            default:       prdata = '0;
        endcase
    end

    ssag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_restart  (i_s_tdata[0]),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ssag_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grid_rows (r_grid_rows),
        .i_grid_cols (r_grid_cols),
        .i_start_row (r_start_row),
        .i_start_col (r_start_col),
        .i_cfg_wr    (w_cfg_wr),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_row       (w_row),
        .o_col       (w_col),
        .o_last      (o_m_tlast),
        .o_done      (o_m_tuser)
    );

    assign o_m_tdata = {w_col, w_row};

endmodule

// ----- tb/sv/tb_spiral_scan_address_generator.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the spiral scan address generator: APB setup, request and result streams.
module tb_spiral_scan_address_generator;
    import ssag_pkg::*;

    // Register map, one 32-bit word per register.
    localparam int REG_GRID_ROWS = 0;
    localparam int REG_GRID_COLS = 1;
    localparam int REG_START_ROW = 2;
    localparam int REG_START_COL = 3;

    // The run stops sending once this many requests have been accepted; the final
    // stretch runs without any idling on either stream.
    localparam int REQUEST_TARGET = 650;
    localparam int CALM_AFTER     = 560;
    localparam int SETTLE_CYCLES  = 20;

    typedef enum bit [1:0] {HEAD_EAST, HEAD_SOUTH, HEAD_WEST, HEAD_NORTH} t_heading;

    // One result as it travels on the result stream.
    typedef struct packed {
        logic [7:0] row_out;
        logic [7:0] col_out;
        logic       is_last;
        logic       done_res;
    } t_spiral_cell;

    // Predicts the spiral visiting order and holds the cells still owed by the block.
    class cell_order_scoreboard;
        bit [8:0] grid_rows = 9'd1;
        bit [8:0] grid_cols = 9'd1;
        bit [7:0] start_row = 8'd0;
        bit [7:0] start_col = 8'd0;
        int       walk_row = 0;
        int       walk_col = 0;
        int       leg_len = 1;
        int       leg_pos = 0;
        int       cells_given = 0;
        t_heading heading = HEAD_EAST;
        t_spiral_cell expected_cells[$];
        int errors = 0;
        int cells_checked = 0;
        int restarts = 0;
        int done_seen = 0;
        int last_seen = 0;
        int reg_writes = 0;

        // Sizes of zero read as one; anything above the largest grid is clipped.
        function int eff_dim(bit [8:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
            return int'(v);
        endfunction

        // Any register write drops the walk in progress.
        function void write_reg(int idx, logic [31:0] value);
            reg_writes++;
            case (idx)
                REG_GRID_ROWS: grid_rows = value[8:0];
                REG_GRID_COLS: grid_cols = value[8:0];
                REG_START_ROW: start_row = value[7:0];
                REG_START_COL: start_col = value[7:0];
                default: return;
            endcase
            cells_given = 0;
        endfunction

        // Called for every accepted request; queues the one cell it must produce.
        function void take_request(bit restart);
            int rows;
            int cols;
            int total;
            int guard;
            bit found;
            t_spiral_cell item;
            rows = eff_dim(grid_rows);
            cols = eff_dim(grid_cols);
            total = rows * cols;
            item = '0;
            if (restart) restarts++;
            if (restart || cells_given == 0) begin
                // A start cell outside the grid saturates to the last row or column.
                walk_row = (int'(start_row) >= rows) ? rows - 1 : int'(start_row);
                walk_col = (int'(start_col) >= cols) ? cols - 1 : int'(start_col);
                leg_len = 1;
                leg_pos = 0;
                heading = HEAD_EAST;
                cells_given = 1;
                item.row_out = walk_row[7:0];
                item.col_out = walk_col[7:0];
                item.is_last = (total == 1);
            end else if (cells_given >= total) begin
                item.done_res = 1'b1;
            end else begin
                guard = 4 * (MAX_DIM_DEF + 1) * (MAX_DIM_DEF + 1) * 4;
                found = 1'b0;
                while (!found) begin
                    case (heading)
                        HEAD_EAST:  walk_col++;
                        HEAD_SOUTH: walk_row++;
                        HEAD_WEST:  walk_col--;
                        default:    walk_row--;
                    endcase
                    leg_pos++;
                    if (leg_pos >= leg_len) begin
                        leg_pos = 0;
                        heading = heading.next();
                        if (heading == HEAD_EAST || heading == HEAD_WEST) leg_len++;
                    end
                    if (walk_row >= 0 && walk_row < rows && walk_col >= 0 && walk_col < cols)
                        found = 1'b1;
                    else if (guard == 0)
                        break;
                    else
                        guard--;
                end
                if (found) begin
                    cells_given++;
                    item.row_out = walk_row[7:0];
                    item.col_out = walk_col[7:0];
                    item.is_last = (cells_given == total);
                end else begin
                    cells_given = total;
                    item.done_res = 1'b1;
                end
            end
            expected_cells.insert(expected_cells.size(), item);
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        endfunction

        // Called for every accepted result; compares it with the oldest cell owed.
        function void check_cell(t_spiral_cell got);
            t_spiral_cell want;
            if (expected_cells.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result row %0d col %0d last %0b done %0b",
                         $time, got.row_out, got.col_out, got.is_last, got.done_res);
                return;
            end
            want = expected_cells.pop_front();
            cells_checked++;
            if (got.is_last === 1'b1) last_seen++;
            if (got.done_res === 1'b1) done_seen++;
            if (got.row_out !== want.row_out) report_field("row_out", want.row_out, got.row_out);
            if (got.col_out !== want.col_out) report_field("col_out", want.col_out, got.col_out);
            if (got.is_last !== want.is_last) report_field("is_last", want.is_last, got.is_last);
            if (got.done_res !== want.done_res)
                report_field("done_res", want.done_res, got.done_res);
        endfunction

        function int outstanding();
            return expected_cells.size();
        endfunction
    endclass

    // Clock, reset and every block input start at a known value.
    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata  = '0;   // [0] restart, upper bits zero
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;         // [7:0] row_out, [15:8] col_out
    logic                  o_m_tlast;         // is_last
    logic                  o_m_tuser;         // done_res

    cell_order_scoreboard board;
    int requests_sent = 0;
    bit calm = 1'b0;

    spiral_scan_address_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Everything is sampled at the rising edge, before the block's own updates land, so
    // every handshake seen here is exactly the one the block saw. Results are checked
    // before the request of the same edge is noted; a result never belongs to it anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                board.check_cell(t_spiral_cell'({o_m_tdata[7:0], o_m_tdata[15:8],
                                                 o_m_tlast, o_m_tuser}));
            if (i_s_tvalid && o_s_tready)
                board.take_request(i_s_tdata[0]);
            if (psel && penable && pwrite && pready)
                board.write_reg(int'(paddr) / 4, pwdata);
        end
    end

    // The result side stalls in random bursts, with longer stretches of steady ready in
    // between; once the run turns calm it stays ready for good.
    initial begin
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    end

    // Hard stop well beyond the slowest correct run, even with long idle bursts and the
    // far-flung walks of the wide grids.
    initial begin
        #2000000;
        $display("Timed out with %0d cells still owed", board.outstanding());
        $display("Some tests failed");
        $finish;
    end

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    // The bus then returns to idle before the next write may start.
    task automatic reg_write(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int rows, input int cols, input int srow, input int scol);
        reg_write(REG_GRID_ROWS, rows);
        reg_write(REG_GRID_COLS, cols);
        reg_write(REG_START_ROW, srow);
        reg_write(REG_START_COL, scol);
    endtask

    // Offers one request and returns at the edge where it is transferred. A random gap may
    // come first, and the valid is only ever touched once per edge.
    task automatic push_request(input bit restart);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        requests_sent++;
        if (requests_sent >= CALM_AFTER) calm = 1'b1;
    endtask

    // Stops requesting and waits until every owed cell has come back. The first edge lets
    // the monitor note the request transferred at the edge this task was entered on.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0) @(posedge i_clk);
    endtask

    // Start coordinate for a grid dimension: mostly inside, sometimes anywhere in the
    // register range so that the saturation to the last row or column is exercised.
    function automatic int pick_start(input int dim);
        int top;
        top = (dim == 0) ? 0 : ((dim > MAX_DIM_DEF) ? MAX_DIM_DEF - 1 : dim - 1);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, top);
    endfunction

    initial begin
        int dim_edges[6] = '{0, 1, 255, 256, 257, 511};
        int rows;
        int cols;
        int swap;
        int walk_len;
        int kind;
        board = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Out of reset the grid is one cell and no walk is active: a plain next request
        // acts as a restart, the second one is already past the end, a restart repeats.
        push_request(1'b0);
        push_request(1'b0);
        push_request(1'b1);
        drain();

        // Zero sizes read as a single cell, and the far start saturates onto it.
        configure(0, 0, 255, 255);
        push_request(1'b1);
        push_request(1'b0);
        drain();

        // A two by three grid, interrupted by a register write after three cells; the
        // walk then starts over from the new start cell and runs to its done marker.
        configure(2, 3, 0, 0);
        repeat (3) push_request(1'b0);
        drain();
        reg_write(REG_START_COL, 1);
        repeat (7) push_request(1'b0);
        drain();

        // Oversized rows clip to the largest grid; starting in the far corner makes the
        // walk step over long runs of positions outside the grid.
        configure(511, 256, 255, 255);
        push_request(1'b1);
        repeat (3) push_request(1'b0);
        drain();

        // A single tall column with the start column saturated to zero.
        configure(256, 1, 200, 7);
        repeat (3) push_request(1'b0);

        // Random phases. Small grids are walked to the end and a little past it, with an
        // odd restart thrown in; thin and large grids only get the opening cells of their
        // walk, since later cells there need long runs of out-of-grid stepping.
        while (requests_sent < REQUEST_TARGET) begin
            drain();
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                rows = $urandom_range(1, 8);
                cols = $urandom_range(1, 8);
                walk_len = rows * cols + $urandom_range(1, 3);
            end else if (kind == 7) begin
                rows = $urandom_range(1, 3);
                cols = $urandom_range(64, 256);
                if ($urandom_range(0, 1) == 1) begin
                    swap = rows;
                    rows = cols;
                    cols = swap;
                end
                walk_len = $urandom_range(3, 10);
            end else if (kind == 8) begin
                rows = $urandom_range(0, 511);
                cols = $urandom_range(0, 511);
                walk_len = $urandom_range(2, 8);
            end else begin
                rows = dim_edges[$urandom_range(0, 5)];
                cols = dim_edges[$urandom_range(0, 5)];
                walk_len = $urandom_range(2, 6);
            end
            configure(rows, cols, pick_start(rows), pick_start(cols));
            for (int k = 0; k < walk_len && requests_sent < REQUEST_TARGET; k++)
                push_request((k == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 19) == 0));
        end

        // Let everything owed come back, then watch a little longer for stray results.
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests (%0d restarts) across %0d register writes.",
                 requests_sent, board.restarts, board.reg_writes);
        $display("%0d cells checked, %0d flagged last, %0d done markers.",
                 board.cells_checked, board.last_seen, board.done_seen);
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
